>>> hw/rtl/solq_pkg.sv
package solq_pkg;

  // Queue geometry.
  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned COST_BITS = 16;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = KEY_BITS + COST_BITS;

  // Stream widths, padded to whole bytes.
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_RAW_W     = KEY_BITS + COST_BITS;
  localparam int unsigned IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W    = STATUS_W + 1 + KEY_BITS + COST_BITS + CNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  // Operation codes; codes five to seven are ignored.
  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_CLEAR    = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_CHK,
    S_HEAD_RD,
    S_DONE
  } state_e;

  // One request as it enters the sequencer.
  typedef struct packed {
    func_e                func;
    logic [KEY_BITS-1:0]  key;
    logic [COST_BITS-1:0] cost;
  } req_t;

  // One result as it leaves the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]     occupancy;
    logic [COST_BITS-1:0] head_cost;
    logic [KEY_BITS-1:0]  head_key;
    logic                 found;
    status_e              status;
  } res_t;

endpackage

>>> hw/rtl/sorted_open_list_queue.sv
// Sorted open-list queue: holds up to 64 (key, cost) entries in ascending cost
// order in a RAM with a registered read, walked by a small sequencer that
// reads, compares and moves one entry at a time. A push drops an older
// entry with the same key when the new cost is lower, then shifts
// larger-or-equal costs up by one and inserts in front of them; pop, remove,
// contains and clear work in place. Each request returns one result with the
// status, the found flag, the head after the request and the occupancy. A
// clear, an ignored code or a push into a full queue visits no entry. The
// result enters the output register at the edge that makes the input ready
// again; while that register holds an untaken result, a finished request
// waits.
module sorted_open_list_queue import solq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: item_key, item_cost.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: func.
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: status, found, head_key, head_cost, occupancy.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  req_t req;
  res_t res, out_q;
  logic res_valid, res_ready, out_valid_q;

  // Unpack the incoming request.
  assign req.func = func_e'(s_axis_tuser);
  assign req.key  = s_axis_tdata[KEY_BITS-1:0];
  assign req.cost = s_axis_tdata[KEY_BITS+COST_BITS-1:KEY_BITS];

  solq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register takes a result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_q};

endmodule

>>> hw/rtl/solq_ram.sv
module solq_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned DataW = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hw/rtl/solq_ctrl.sv
module solq_ctrl import solq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  state_e               state_q, state_d;
  func_e                op_q, op_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [COST_BITS-1:0] cost_q, cost_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     total_q, total_d;
  status_e              status_q, status_d;
  logic                 found_q, found_d;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0]  rd_key;
  logic [COST_BITS-1:0] rd_cost;
  logic [ENTRY_W-1:0]   new_entry;
  logic [CNT_W-1:0]     idx_inc, idx_dec;
  logic                 key_hit, cost_lower, shift_up, last_find, del_last;
  logic                 is_full, is_empty, idx_zero;

  // Entry store: cost in the upper half, key in the lower half.
  solq_ram #(
    .Depth (CAPACITY),
    .DataW (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compare unit working on the entry just read.
  assign rd_key     = ram_rdata[KEY_BITS-1:0];
  assign rd_cost    = ram_rdata[ENTRY_W-1:KEY_BITS];
  assign new_entry  = {cost_q, key_q};
  assign key_hit    = (rd_key == key_q);
  assign cost_lower = (cost_q < rd_cost);
  assign shift_up   = (rd_cost >= cost_q);
  assign idx_inc    = idx_q + CNT_W'(1);
  assign idx_dec    = idx_q - CNT_W'(1);
  assign last_find  = (idx_inc == total_q);
  assign del_last   = (idx_inc >= total_q);
  assign idx_zero   = (idx_q == '0);
  assign is_full    = (total_q == CNT_W'(CAPACITY));
  assign is_empty   = (total_q == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (req_i.func)
            OP_PUSH: begin
              if (is_full) state_d = S_HEAD_RD;
              else if (is_empty) state_d = S_INS_RD;
              else state_d = S_FIND_RD;
            end
            OP_POP: state_d = is_empty ? S_HEAD_RD : S_DEL_RD;
            OP_REMOVE, OP_CONTAINS: state_d = is_empty ? S_HEAD_RD : S_FIND_RD;
            default: state_d = S_HEAD_RD;
          endcase
        end
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (key_hit) begin
          unique case (op_q)
            OP_PUSH:   state_d = cost_lower ? S_DEL_RD : S_INS_RD;
            OP_REMOVE: state_d = S_DEL_RD;
            default:   state_d = S_HEAD_RD;
          endcase
        end else if (last_find) begin
          state_d = (op_q == OP_PUSH) ? S_INS_RD : S_HEAD_RD;
        end else begin
          state_d = S_FIND_RD;
        end
      end
      S_DEL_RD: begin
        if (del_last) state_d = (op_q == OP_PUSH) ? S_INS_RD : S_HEAD_RD;
        else state_d = S_DEL_WR;
      end
      S_DEL_WR:  state_d = S_DEL_RD;
      S_INS_RD:  state_d = idx_zero ? S_HEAD_RD : S_INS_CHK;
      S_INS_CHK: state_d = shift_up ? S_INS_RD : S_HEAD_RD;
      S_HEAD_RD: state_d = S_DONE;
      S_DONE:    state_d = res_ready_i ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[ADDR_W-1:0];
    unique case (state_q)
      S_FIND_RD: ram_re = 1'b1;
      S_DEL_RD: begin
        ram_re    = !del_last;
        ram_raddr = idx_inc[ADDR_W-1:0];
      end
      S_DEL_WR: ram_we = 1'b1;
      S_INS_RD: begin
        if (idx_zero) begin
          ram_we    = 1'b1;
          ram_wdata = new_entry;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[ADDR_W-1:0];
        end
      end
      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = shift_up ? ram_rdata : new_entry;
      end
      S_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      default: ;
    endcase
  end

  assign req_ready_o     = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_DONE);
  assign res_o.status    = status_q;
  assign res_o.found     = found_q;
  assign res_o.head_key  = is_empty ? '0 : rd_key;
  assign res_o.head_cost = is_empty ? '0 : rd_cost;
  assign res_o.occupancy = total_q;

  // Working registers: operands, scan index, count and status.
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    cost_d   = cost_q;
    idx_d    = idx_q;
    total_d  = total_q;
    status_d = status_q;
    found_d  = found_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.func;
          key_d    = req_i.key;
          cost_d   = req_i.cost;
          idx_d    = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          unique case (req_i.func)
            OP_PUSH:   if (is_full) status_d = ST_FULL;
            OP_POP:    if (is_empty) status_d = ST_EMPTY;
            OP_REMOVE: if (is_empty) status_d = ST_NOT_FOUND;
            OP_CLEAR:  total_d = '0;
            default: ;
          endcase
        end
      end
      S_FIND_CHK: begin
        if (key_hit) begin
          if (op_q == OP_PUSH && !cost_lower) idx_d = total_q;
          if (op_q == OP_CONTAINS) found_d = 1'b1;
        end else if (last_find) begin
          if (op_q == OP_PUSH) idx_d = total_q;
          if (op_q == OP_REMOVE) status_d = ST_NOT_FOUND;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_DEL_RD: begin
        if (del_last) begin
          total_d = total_q - CNT_W'(1);
          idx_d   = total_q - CNT_W'(1);
        end
      end
      S_DEL_WR: idx_d = idx_inc;
      S_INS_RD: if (idx_zero) total_d = total_q + CNT_W'(1);
      S_INS_CHK: begin
        if (shift_up) idx_d = idx_dec;
        else total_d = total_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      status_q <= ST_OK;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    cost_q <= cost_d;
    idx_q  <= idx_d;
  end

  // The count never exceeds the capacity.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every write lands inside the store.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (idx_q < CNT_W'(CAPACITY)))
    else $error("write index out of range");

  // A finished result waits until it is taken.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped before it was taken");

  // A full status only comes from a push into a full queue.
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ST_FULL) |-> (op_q == OP_PUSH && is_full))
    else $error("full status without a full push");

  // Found is only reported for a contains request.
  a_found_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (op_q == OP_CONTAINS))
    else $error("found flag on a non-contains request");

endmodule

>>> tb/sv/tb_sorted_open_list_queue.sv
module tb_sorted_open_list_queue import solq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Function codes that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int SEGMENT_LEN = 85;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 50;

  localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  // One stored entry of the open list.
  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [COST_BITS-1:0] cost;
  } slot_t;

  // Tracks the sorted contents of the queue and the results still owed.
  class queue_tracker;
    slot_t       entries[$];
    res_t        pending_results[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Index of the first entry holding this key, or -1.
    function int find_key(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < entries.size(); i++) begin
        if (entries[i].key == key) return i;
      end
      return -1;
    endfunction

    // A key that is stored most of the time, so removes and lookups hit.
    function logic [KEY_BITS-1:0] pick_key();
      if (entries.size() > 0 && $urandom_range(0, 9) < 7)
        return entries[$urandom_range(0, entries.size() - 1)].key;
      return KEY_BITS'($urandom);
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(logic [FUNC_W-1:0] func, logic [KEY_BITS-1:0] key,
                               logic [COST_BITS-1:0] cost);
      res_t  want;
      int    idx;
      int    pos;
      slot_t fresh;
      want = '0;
      want.status = ST_OK;
      case (func)
        OP_PUSH: begin
          if (entries.size() >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            // A cheaper push replaces the first entry with the same key.
            idx = find_key(key);
            if (idx >= 0 && cost < entries[idx].cost) entries.delete(idx);
            // Insert ahead of the first entry that is not cheaper.
            pos = 0;
            while (pos < entries.size() && cost > entries[pos].cost) pos++;
            fresh.key = key;
            fresh.cost = cost;
            entries.insert(pos, fresh);
          end
        end
        OP_POP: begin
          if (entries.size() == 0) want.status = ST_EMPTY;
          else entries.delete(0);
        end
        OP_REMOVE: begin
          idx = find_key(key);
          if (idx >= 0) entries.delete(idx);
          else want.status = ST_NOT_FOUND;
        end
        OP_CONTAINS: want.found = (find_key(key) >= 0);
        OP_CLEAR: entries.delete();
        default: ;
      endcase
      if (entries.size() > 0) begin
        want.head_key = entries[0].key;
        want.head_cost = entries[0].cost;
      end
      want.occupancy = CNT_W'(entries.size());
      pending_results.insert(pending_results.size(), want);
    endfunction

    function void check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(logic [OUT_DATA_W-1:0] data);
      res_t got;
      res_t want;
      got = res_t'(data[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %0h", $time, data);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("found", want.found, got.found);
      check_field("head_key", want.head_key, got.head_key);
      check_field("head_cost", want.head_cost, got.head_cost);
      check_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  queue_tracker        tracker = new();
  int                  sent_requests = 0;
  bit                  calm_phase = 1'b0;
  logic [KEY_BITS-1:0] wide_keys[8];

  sorted_open_list_queue uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle cycles before the next request or result; none in calm phases.
  function int draw_wait();
    return calm_phase ? 0 : $urandom_range(0, 15);
  endfunction

  // Mostly a few small keys so that matches are common.
  function logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(0, 3))
      0, 1: return KEY_BITS'($urandom_range(0, 15));
      2: return wide_keys[$urandom_range(0, 7)];
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Costs at both ends and a narrow band that produces ties.
  function logic [COST_BITS-1:0] draw_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COST_MAX;
      2, 3, 4, 5: return COST_BITS'($urandom_range(0, 7));
      default: return COST_BITS'($urandom);
    endcase
  endfunction

  // Offer one request and return at the edge that accepts it.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_BITS-1:0] key,
                              input logic [COST_BITS-1:0] cost);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({cost, key});
    s_axis_tuser <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(func, key, cost);
    sent_requests++;
  endtask

  // Result side: random stalls and one long hold-off that backs up the input.
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tdata);
        stall_left = draw_wait();
      end
      if (!hold_done && sent_requests >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int counted;
    int seg;
    int push_weight;
    int pick;
    foreach (wide_keys[i]) wide_keys[i] = KEY_BITS'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, extremes, replacement, duplicates, ties and ignored codes.
    send_request(OP_POP, '0, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_CONTAINS, KEY_MAX, COST_MAX);
    send_request(OP_PUSH, '0, COST_MAX);
    send_request(OP_PUSH, KEY_MAX, '0);
    send_request(OP_PUSH, '0, 16'd8);
    send_request(OP_PUSH, '0, 16'd100);
    send_request(OP_PUSH, 16'd5, 16'd8);
    send_request(OP_PUSH, KEY_MAX, '0);
    send_request(OP_CONTAINS, '0, '0);
    send_request(OP_CONTAINS, 16'h1234, COST_MAX);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_REMOVE, 16'h4321, '0);
    send_request(FUNC_UNUSED_LO, 16'hAAAA, 16'h5555);
    send_request(FUNC_UNUSED_MID, 16'h5555, 16'hAAAA);
    send_request(FUNC_UNUSED_HI, KEY_MAX, COST_MAX);
    send_request(OP_POP, KEY_MAX, COST_MAX);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_PUSH, 16'd3, 16'd3);
    send_request(OP_CLEAR, KEY_MAX, COST_MAX);

    // Random phases alternate between filling past capacity and draining.
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      seg = counted / SEGMENT_LEN;
      calm_phase = (seg % 5 == 3);
      case (seg % 4)
        0: push_weight = 95;
        1: push_weight = 15;
        2: push_weight = 55;
        default: push_weight = 85;
      endcase
      if ($urandom_range(0, 99) < push_weight) begin
        send_request(OP_PUSH, draw_key(), draw_cost());
        counted++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_request(OP_POP, draw_key(), draw_cost());
          counted++;
        end else if (pick < 65) begin
          send_request(OP_REMOVE, tracker.pick_key(), draw_cost());
          counted++;
        end else if (pick < 90) begin
          send_request(OP_CONTAINS, tracker.pick_key(), draw_cost());
          counted++;
        end else if (pick < 94) begin
          send_request(OP_CLEAR, draw_key(), draw_cost());
          counted++;
        end else begin
          send_request(FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)),
                       draw_key(), draw_cost());
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let every owed result come back, then a short quiet stretch.
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
